/* rtl/lcs_pkg.sv */
// shared types, constants and arithmetic helpers of the lstm cell sequence block
`timescale 1ns / 1ps

package lcs_pkg;

  // sizes and fixed point format
  localparam int DEF_MAX_INPUT  = 64;
  localparam int DEF_MAX_HIDDEN = 64;
  localparam int DW             = 16;
  localparam int FRAC_BITS      = 12;
  localparam int ACC_W          = 48;
  localparam int FIFO_DEPTH     = 4;

  typedef logic signed [DW-1:0] data_t;

  // action codes of an input beat
  localparam logic [2:0] ACTION_LOAD_W = 3'd0;
  localparam logic [2:0] ACTION_LOAD_U = 3'd1;
  localparam logic [2:0] ACTION_LOAD_B = 3'd2;
  localparam logic [2:0] ACTION_CLEAR  = 3'd3;
  localparam logic [2:0] ACTION_ELEM   = 3'd4;

  // gate codes
  localparam logic [1:0] GATE_IN     = 2'd0;
  localparam logic [1:0] GATE_FORGET = 2'd1;
  localparam logic [1:0] GATE_CAND   = 2'd2;
  localparam logic [1:0] GATE_OUT    = 2'd3;

  // activation codes
  localparam logic [2:0] FN_SIGMOID = 3'd0;
  localparam logic [2:0] FN_HARD    = 3'd1;
  localparam logic [2:0] FN_TANH    = 3'd2;
  localparam logic [2:0] FN_LINEAR  = 3'd3;
  localparam logic [2:0] FN_RELU    = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_INPUT_SIZE  = 3'd0;
  localparam logic [2:0] CFG_HIDDEN_SIZE = 3'd1;
  localparam logic [2:0] CFG_GATE_ACT    = 3'd2;
  localparam logic [2:0] CFG_CELL_ACT    = 3'd3;
  localparam logic [2:0] CFG_RET_SEQ     = 3'd4;

  typedef enum logic [2:0] {
    CMD_LOAD_W,
    CMD_LOAD_U,
    CMD_LOAD_B,
    CMD_CLEAR,
    CMD_ELEM
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [1:0] gate;
    logic [5:0] row;
    logic [5:0] col;
    data_t      value;
    logic       store_ok;
    logic       last;
    logic       fin;
  } cmd_t;

  typedef struct packed {
    logic [6:0] input_size;
    logic [6:0] hidden_size;
    logic [2:0] gate_act;
    logic [2:0] cell_act;
    logic       ret_seq;
  } cfg_t;

  // tanh at steps of 0.25 from 0 to 4
  function automatic logic [12:0] tanh_lut(logic [4:0] idx);
    logic [12:0] v;
    case (idx)
      5'd0:    v = 13'd0;
      5'd1:    v = 13'd1003;
      5'd2:    v = 13'd1893;
      5'd3:    v = 13'd2602;
      5'd4:    v = 13'd3119;
      5'd5:    v = 13'd3475;
      5'd6:    v = 13'd3707;
      5'd7:    v = 13'd3856;
      5'd8:    v = 13'd3949;
      5'd9:    v = 13'd4006;
      5'd10:   v = 13'd4041;
      5'd11:   v = 13'd4062;
      5'd12:   v = 13'd4076;
      5'd13:   v = 13'd4084;
      5'd14:   v = 13'd4089;
      5'd15:   v = 13'd4091;
      default: v = 13'd4093;
    endcase
    return v;
  endfunction

  // saturate a wide signed value to a data word
  function automatic data_t sat_data(logic signed [ACC_W-1:0] v);
    data_t r;
    if (v > 48'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -48'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  // interpolated tanh of a magnitude
  function automatic logic [12:0] tanh_mag(logic [16:0] a);
    logic [5:0]  idx;
    logic [12:0] t0;
    logic [12:0] t1;
    logic [22:0] prod;
    logic [12:0] r;
    idx  = 6'(a >> 10);
    t0   = tanh_lut(idx[4:0]);
    t1   = tanh_lut(idx[4:0] + 5'd1);
    prod = {10'b0, 13'(t1 - t0)} * {13'b0, a[9:0]};
    if (idx >= 6'd16) begin
      r = 13'd4093;
    end else begin
      r = t0 + 13'(prod >> 10);
    end
    return r;
  endfunction

  // activation by code, unknown codes pass through
  function automatic data_t activate(logic [2:0] sel, data_t x);
    logic [16:0]        a;
    logic [12:0]        t;
    logic [35:0]        qm;
    logic signed [17:0] q;
    data_t              r;
    a  = x[DW-1] ? 17'(~{1'b1, x} + 17'd1) : {1'b0, x};
    t  = 13'd0;
    qm = 36'd0;
    q  = 18'sd0;
    case (sel)
      FN_SIGMOID: begin
        t = tanh_mag(a >> 1) >> 1;
        r = x[DW-1] ? data_t'(16'd2048 - {3'b0, t}) : data_t'(16'd2048 + {3'b0, t});
      end
      FN_HARD: begin
        // floor(x/5) by reciprocal, exact for 17 bit magnitudes
        if (!x[DW-1]) begin
          qm = 36'(a) * 36'd52429;
          q  = signed'(18'(qm >> 18));
        end else begin
          qm = 36'(a + 17'd4) * 36'd52429;
          q  = -signed'(18'(qm >> 18));
        end
        q = q + 18'sd2048;
        if (q < 18'sd0) begin
          q = 18'sd0;
        end else if (q > 18'sd4096) begin
          q = 18'sd4096;
        end
        r = data_t'(q[DW-1:0]);
      end
      FN_TANH: begin
        t = tanh_mag(a);
        r = x[DW-1] ? data_t'(-signed'({3'b0, t})) : data_t'({3'b0, t});
      end
      FN_RELU: begin
        r = x[DW-1] ? 16'sd0 : x;
      end
      default: begin
        r = x;
      end
    endcase
    return r;
  endfunction

endpackage

/* rtl/lcs_if.sv */
// valid/ready channel interfaces for input and result beats
`timescale 1ns / 1ps

interface lcs_in_if;
  logic          valid;
  logic          ready;
  logic [2:0]    action;
  logic [1:0]    gate_select;
  logic [5:0]    row_index;
  logic [5:0]    col_index;
  lcs_pkg::data_t value;
  logic          last_element;
  logic          final_step;

  modport source (
    output valid, action, gate_select, row_index, col_index, value, last_element, final_step,
    input  ready
  );
  modport sink (
    input  valid, action, gate_select, row_index, col_index, value, last_element, final_step,
    output ready
  );
endinterface

interface lcs_out_if;
  logic          valid;
  logic          ready;
  logic [5:0]    h_index;
  lcs_pkg::data_t h_value;
  logic          last_of_run;

  modport source (
    output valid, h_index, h_value, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, h_index, h_value, last_of_run,
    output ready
  );
endinterface

/* rtl/lcs_front.sv */
// front end: accepts input beats and turns them into queued commands
`timescale 1ns / 1ps

module lcs_front #(
  parameter int MAX_INPUT  = lcs_pkg::DEF_MAX_INPUT,
  parameter int MAX_HIDDEN = lcs_pkg::DEF_MAX_HIDDEN
) (
  lcs_in_if.sink        in_if,
  input  logic          full_i,
  output logic          push_o,
  output lcs_pkg::cmd_t cmd_o
);

  logic keep;
  logic row_in_x;
  logic row_in_h;
  logic col_in_h;

  assign row_in_x = 32'(in_if.row_index) < MAX_INPUT;
  assign row_in_h = 32'(in_if.row_index) < MAX_HIDDEN;
  assign col_in_h = 32'(in_if.col_index) < MAX_HIDDEN;

  // classify the beat, drop loads outside the stores and unknown actions
  always_comb begin
    cmd_o.gate     = in_if.gate_select;
    cmd_o.row      = in_if.row_index;
    cmd_o.col      = in_if.col_index;
    cmd_o.value    = in_if.value;
    cmd_o.last     = in_if.last_element;
    cmd_o.fin      = in_if.final_step;
    cmd_o.store_ok = 1'b0;
    cmd_o.kind     = lcs_pkg::CMD_CLEAR;
    keep           = 1'b0;
    case (in_if.action)
      lcs_pkg::ACTION_LOAD_W: begin
        cmd_o.kind = lcs_pkg::CMD_LOAD_W;
        keep       = row_in_x && col_in_h;
      end
      lcs_pkg::ACTION_LOAD_U: begin
        cmd_o.kind = lcs_pkg::CMD_LOAD_U;
        keep       = row_in_h && col_in_h;
      end
      lcs_pkg::ACTION_LOAD_B: begin
        cmd_o.kind = lcs_pkg::CMD_LOAD_B;
        keep       = col_in_h;
      end
      lcs_pkg::ACTION_CLEAR: begin
        cmd_o.kind = lcs_pkg::CMD_CLEAR;
        keep       = 1'b1;
      end
      lcs_pkg::ACTION_ELEM: begin
        cmd_o.kind     = lcs_pkg::CMD_ELEM;
        cmd_o.store_ok = row_in_x;
        keep           = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_if.ready = !full_i;
  assign push_o      = in_if.valid && !full_i && keep;

endmodule

/* rtl/lcs_fifo.sv */
// short command queue between front and back end
`timescale 1ns / 1ps

module lcs_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lcs_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output lcs_pkg::cmd_t head_o
);

  localparam int PW = $clog2(lcs_pkg::FIFO_DEPTH);
  localparam int CW = $clog2(lcs_pkg::FIFO_DEPTH + 1);

  lcs_pkg::cmd_t   mem_q [lcs_pkg::FIFO_DEPTH];
  logic [PW-1:0]   wr_q, wr_d;
  logic [PW-1:0]   rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = cnt_q == CW'(lcs_pkg::FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointers and fill count
  always_comb begin
    wr_d  = do_push ? wr_q + PW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + PW'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/lcs_back.sv */
// back end: weight stores, shared mac unit, cell update and result register
`timescale 1ns / 1ps

module lcs_back #(
  parameter int MAX_INPUT  = lcs_pkg::DEF_MAX_INPUT,
  parameter int MAX_HIDDEN = lcs_pkg::DEF_MAX_HIDDEN
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lcs_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  input  lcs_pkg::cmd_t cmd_i,
  output logic          pop_o,
  lcs_out_if.source     out_if
);

  localparam int RW    = (MAX_INPUT > 1) ? $clog2(MAX_INPUT) : 1;
  localparam int KW    = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
  localparam int RCW   = (RW > KW) ? RW : KW;
  localparam int NIW   = $clog2(MAX_INPUT + 1);
  localparam int NHW   = $clog2(MAX_HIDDEN + 1);
  localparam int XD    = 1 << RW;
  localparam int HD    = 1 << KW;
  localparam int WD    = 4 << (RW + KW);
  localparam int UD    = 4 << (KW + KW);
  localparam int BD    = 4 << KW;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BIAS,
    S_ISSUE,
    S_DRAIN,
    S_PRE,
    S_ACT,
    S_FC,
    S_IC,
    S_CSUM,
    S_CA,
    S_H,
    S_CP_RD,
    S_CP_WR
  } state_e;

  state_e state_q;

  // loop counters and step flags
  logic [KW-1:0]  k_q;
  logic [1:0]     g_q;
  logic [RCW-1:0] r_q;
  logic           ph_q;
  logic           first_q;
  logic           emit_q;

  // mac pipeline control
  logic v1_q, v2_q, ph1_q;

  // result register
  logic           out_valid_q;
  logic [5:0]     out_idx_q;
  lcs_pkg::data_t out_val_q;
  logic           out_last_q;

  // state valid flags for h and c
  logic [HD-1:0] h_vld_q;
  logic [HD-1:0] c_vld_q;

  // memories and registered read data
  lcs_pkg::data_t w_mem [WD];
  lcs_pkg::data_t u_mem [UD];
  lcs_pkg::data_t b_mem [BD];
  lcs_pkg::data_t x_mem [XD];
  lcs_pkg::data_t h_mem [HD];
  lcs_pkg::data_t c_mem [HD];
  lcs_pkg::data_t hn_mem [HD];
  lcs_pkg::data_t w_rd_q, u_rd_q, b_rd_q, x_rd_q, h_rd_q, c_rd_q, hn_rd_q;
  logic           hv_rd_q, cv_rd_q;

  // datapath registers
  logic signed [lcs_pkg::ACC_W-1:0] acc_q;
  logic signed [2*lcs_pkg::DW-1:0]  prod_q;
  lcs_pkg::data_t                   pre_q, fc_q, ic_q, cn_q, ca_q;
  lcs_pkg::data_t                   gate_q [4];

  // sizes and loop bounds
  logic [NIW-1:0] ni, ni_m1;
  logic [NHW-1:0] nh, nh_m1;
  logic [RCW-1:0] r_last;
  logic           k_last;
  logic           can_go;
  logic           issue;

  // shared multiplier and activation
  lcs_pkg::data_t                  mul_a, mul_b;
  logic signed [2*lcs_pkg::DW-1:0] mul_p;
  lcs_pkg::data_t                  mul_s;
  lcs_pkg::data_t                  act_in, act_out;
  logic [2:0]                      act_sel;
  lcs_pkg::data_t                  c_cur, h_cur;

  // memory write controls
  logic                    w_we, u_we, b_we, x_we, c_we, hn_we, h_we;
  logic [RW+KW+1:0]        w_wa, w_ra;
  logic [2*KW+1:0]         u_wa, u_ra;
  logic [KW+1:0]           b_wa, b_ra;

  // clamp the sizes
  always_comb begin
    if (cfg_i.input_size == 7'd0) begin
      ni = NIW'(1);
    end else if (32'(cfg_i.input_size) > MAX_INPUT) begin
      ni = NIW'(MAX_INPUT);
    end else begin
      ni = NIW'(cfg_i.input_size);
    end
    if (cfg_i.hidden_size == 7'd0) begin
      nh = NHW'(1);
    end else if (32'(cfg_i.hidden_size) > MAX_HIDDEN) begin
      nh = NHW'(MAX_HIDDEN);
    end else begin
      nh = NHW'(cfg_i.hidden_size);
    end
  end

  assign ni_m1  = ni - NIW'(1);
  assign nh_m1  = nh - NHW'(1);
  assign r_last = ph_q ? RCW'(nh_m1) : RCW'(ni_m1);
  assign k_last = k_q == KW'(nh_m1);
  assign issue  = state_q == S_ISSUE;
  assign can_go = !emit_q || !out_valid_q || out_if.ready;
  assign pop_o  = (state_q == S_IDLE) && cmd_valid_i;

  // write strobes and addresses
  assign w_we  = pop_o && (cmd_i.kind == lcs_pkg::CMD_LOAD_W);
  assign u_we  = pop_o && (cmd_i.kind == lcs_pkg::CMD_LOAD_U);
  assign b_we  = pop_o && (cmd_i.kind == lcs_pkg::CMD_LOAD_B);
  assign x_we  = pop_o && (cmd_i.kind == lcs_pkg::CMD_ELEM) && cmd_i.store_ok;
  assign c_we  = state_q == S_CA;
  assign hn_we = state_q == S_H;
  assign h_we  = (state_q == S_CP_WR) && can_go;
  assign w_wa  = {cmd_i.gate, RW'(cmd_i.row), KW'(cmd_i.col)};
  assign u_wa  = {cmd_i.gate, KW'(cmd_i.row), KW'(cmd_i.col)};
  assign b_wa  = {cmd_i.gate, KW'(cmd_i.col)};
  assign w_ra  = {g_q, r_q[RW-1:0], k_q};
  assign u_ra  = {g_q, r_q[KW-1:0], k_q};
  assign b_ra  = {g_q, k_q};

  // store ports
  always_ff @(posedge clk_i) begin
    if (w_we) begin
      w_mem[w_wa] <= cmd_i.value;
    end
    w_rd_q <= w_mem[w_ra];
  end

  always_ff @(posedge clk_i) begin
    if (u_we) begin
      u_mem[u_wa] <= cmd_i.value;
    end
    u_rd_q <= u_mem[u_ra];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      b_mem[b_wa] <= cmd_i.value;
    end
    b_rd_q <= b_mem[b_ra];
  end

  always_ff @(posedge clk_i) begin
    if (x_we) begin
      x_mem[RW'(cmd_i.row)] <= cmd_i.value;
    end
    x_rd_q <= x_mem[r_q[RW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      h_mem[k_q] <= hn_rd_q;
    end
    h_rd_q  <= h_mem[r_q[KW-1:0]];
    hv_rd_q <= h_vld_q[r_q[KW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      c_mem[k_q] <= cn_q;
    end
    c_rd_q  <= c_mem[k_q];
    cv_rd_q <= c_vld_q[k_q];
  end

  always_ff @(posedge clk_i) begin
    if (hn_we) begin
      hn_mem[k_q] <= mul_s;
    end
    hn_rd_q <= hn_mem[k_q];
  end

  assign h_cur = hv_rd_q ? h_rd_q : '0;
  assign c_cur = cv_rd_q ? c_rd_q : '0;

  // operand select for the elementwise multiplier
  always_comb begin
    case (state_q)
      S_FC: begin
        mul_a = gate_q[lcs_pkg::GATE_FORGET];
        mul_b = c_cur;
      end
      S_IC: begin
        mul_a = gate_q[lcs_pkg::GATE_IN];
        mul_b = gate_q[lcs_pkg::GATE_CAND];
      end
      default: begin
        mul_a = gate_q[lcs_pkg::GATE_OUT];
        mul_b = ca_q;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign mul_s   = lcs_pkg::sat_data(lcs_pkg::ACC_W'(mul_p) >>> lcs_pkg::FRAC_BITS);
  assign act_in  = (state_q == S_CA) ? cn_q : pre_q;
  assign act_sel = ((state_q == S_CA) || (g_q == lcs_pkg::GATE_CAND)) ?
                   cfg_i.cell_act : cfg_i.gate_act;
  assign act_out = lcs_pkg::activate(act_sel, act_in);

  // mac pipeline and cell datapath
  always_ff @(posedge clk_i) begin
    prod_q <= ph1_q ? h_cur * u_rd_q : x_rd_q * w_rd_q;
    if (issue && first_q) begin
      acc_q <= lcs_pkg::ACC_W'(b_rd_q) <<< lcs_pkg::FRAC_BITS;
    end else if (v2_q) begin
      acc_q <= acc_q + lcs_pkg::ACC_W'(prod_q);
    end
    if (state_q == S_PRE) begin
      pre_q <= lcs_pkg::sat_data(acc_q >>> lcs_pkg::FRAC_BITS);
    end
    if (state_q == S_ACT) begin
      gate_q[g_q] <= act_out;
    end
    if (state_q == S_FC) begin
      fc_q <= mul_s;
    end
    if (state_q == S_IC) begin
      ic_q <= mul_s;
    end
    if (state_q == S_CSUM) begin
      cn_q <= lcs_pkg::sat_data(lcs_pkg::ACC_W'(fc_q) + lcs_pkg::ACC_W'(ic_q));
    end
    if (state_q == S_CA) begin
      ca_q <= act_out;
    end
  end

  // sequencer, valid flags and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      g_q         <= '0;
      r_q         <= '0;
      ph_q        <= 1'b0;
      first_q     <= 1'b0;
      emit_q      <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      ph1_q       <= 1'b0;
      h_vld_q     <= '0;
      c_vld_q     <= '0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_val_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      v1_q  <= issue;
      ph1_q <= ph_q;
      v2_q  <= v1_q;
      if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            if (cmd_i.kind == lcs_pkg::CMD_CLEAR) begin
              h_vld_q <= '0;
              c_vld_q <= '0;
            end
            if ((cmd_i.kind == lcs_pkg::CMD_ELEM) && cmd_i.last) begin
              emit_q  <= cfg_i.ret_seq || cmd_i.fin;
              k_q     <= '0;
              g_q     <= '0;
              state_q <= S_BIAS;
            end
          end
        end
        S_BIAS: begin
          r_q     <= '0;
          ph_q    <= 1'b0;
          first_q <= 1'b1;
          state_q <= S_ISSUE;
        end
        S_ISSUE: begin
          first_q <= 1'b0;
          if (r_q == r_last) begin
            r_q <= '0;
            if (ph_q) begin
              state_q <= S_DRAIN;
            end else begin
              ph_q <= 1'b1;
            end
          end else begin
            r_q <= r_q + RCW'(1);
          end
        end
        S_DRAIN: begin
          if (!v1_q && !v2_q) begin
            state_q <= S_PRE;
          end
        end
        S_PRE: begin
          state_q <= S_ACT;
        end
        S_ACT: begin
          if (g_q == lcs_pkg::GATE_OUT) begin
            state_q <= S_FC;
          end else begin
            g_q     <= g_q + 2'd1;
            state_q <= S_BIAS;
          end
        end
        S_FC: begin
          state_q <= S_IC;
        end
        S_IC: begin
          state_q <= S_CSUM;
        end
        S_CSUM: begin
          c_vld_q[k_q] <= 1'b1;
          state_q      <= S_CA;
        end
        S_CA: begin
          state_q <= S_H;
        end
        S_H: begin
          g_q <= '0;
          if (k_last) begin
            k_q     <= '0;
            state_q <= S_CP_RD;
          end else begin
            k_q     <= k_q + KW'(1);
            state_q <= S_BIAS;
          end
        end
        S_CP_RD: begin
          state_q <= S_CP_WR;
        end
        S_CP_WR: begin
          if (can_go) begin
            h_vld_q[k_q] <= 1'b1;
            if (emit_q) begin
              out_valid_q <= 1'b1;
              out_idx_q   <= 6'(k_q);
              out_val_q   <= hn_rd_q;
              out_last_q  <= k_last;
            end
            if (k_last) begin
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_q + KW'(1);
              state_q <= S_CP_RD;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.h_index     = out_idx_q;
  assign out_if.h_value     = out_val_q;
  assign out_if.last_of_run = out_last_q;

endmodule

/* rtl/lstm_cell_sequence.sv */
// top level of the lstm cell sequence block: config registers, front, queue, back
//
//  channel  dir  beat                                           accepted when
//  in_if    in   action, gate, row, col, value, last, final     valid && ready
//  out_if   out  h_index, h_value, last_of_run                  valid && ready
//  cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i                cfg_we_i high
//
// loads, clears and plain elements are taken by the back end from the queue while it is idle
// a step (element with last set) is computed by
// the single shared multiply-accumulate unit that walks every weight once
// h and c reset to zero through per-entry valid flags, no clearing pass
// input stalls only when the four-entry queue is full; result stalls hold the copy
`timescale 1ns / 1ps

module lstm_cell_sequence #(
  parameter int MAX_INPUT  = lcs_pkg::DEF_MAX_INPUT,
  parameter int MAX_HIDDEN = lcs_pkg::DEF_MAX_HIDDEN
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lcs_in_if.sink     in_if,
  lcs_out_if.source  out_if,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [6:0] cfg_data_i
);

  lcs_pkg::cfg_t cfg_q;
  lcs_pkg::cmd_t push_cmd;
  lcs_pkg::cmd_t head_cmd;
  logic          push;
  logic          full;
  logic          pop;
  logic          head_valid;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.input_size  <= 7'd64;
      cfg_q.hidden_size <= 7'd64;
      cfg_q.gate_act    <= lcs_pkg::FN_HARD;
      cfg_q.cell_act    <= lcs_pkg::FN_TANH;
      cfg_q.ret_seq     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lcs_pkg::CFG_INPUT_SIZE:  cfg_q.input_size  <= cfg_data_i;
        lcs_pkg::CFG_HIDDEN_SIZE: cfg_q.hidden_size <= cfg_data_i;
        lcs_pkg::CFG_GATE_ACT:    cfg_q.gate_act    <= cfg_data_i[2:0];
        lcs_pkg::CFG_CELL_ACT:    cfg_q.cell_act    <= cfg_data_i[2:0];
        lcs_pkg::CFG_RET_SEQ:     cfg_q.ret_seq     <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  lcs_front #(
    .MAX_INPUT  (MAX_INPUT),
    .MAX_HIDDEN (MAX_HIDDEN)
  ) u_front (
    .in_if  (in_if),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  lcs_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .head_o      (head_cmd)
  );

  lcs_back #(
    .MAX_INPUT  (MAX_INPUT),
    .MAX_HIDDEN (MAX_HIDDEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_if      (out_if)
  );

endmodule

/* bench/lcs_checker.sv */
// scoreboard of the lstm cell sequence bench: predicts h beats and compares them
`timescale 1ns / 1ps

module lcs_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  lcs_in_if          in_mon,
  lcs_out_if         out_mon,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [6:0] cfg_data_i,
  output int         mismatch_count_o,
  output int         pending_o
);

  typedef struct {
    logic [5:0]     idx;
    lcs_pkg::data_t val;
    logic           last;
  } h_beat_t;

  // tanh at quarter steps, Q4.12
  localparam int TANH_PTS [17] = '{0, 1003, 1893, 2602, 3119, 3475, 3707, 3856, 3949,
                                   4006, 4041, 4062, 4076, 4084, 4089, 4091, 4093};

  // configuration copy, raw register contents
  logic [6:0] reg_in_size, reg_hid_size;
  logic [2:0] reg_gate_fn, reg_cell_fn;
  logic       reg_ret_seq;

  // model state
  int w_in   [4][64][64];
  int w_rec  [4][64][64];
  int bias   [4][64];
  int x_vec  [64];
  int h_st   [64];
  int c_st   [64];
  int gate_v [4][64];

  h_beat_t h_expect_q [$];

  function automatic int sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic int clamp_len(logic [6:0] n);
    if (n == 0) return 1;
    return (n > 64) ? 64 : int'(n);
  endfunction

  function automatic int tanh_abs(longint a);
    longint seg, frac;
    seg  = a >> 10;
    frac = a & 1023;
    if (seg >= 16) return TANH_PTS[16];
    return TANH_PTS[seg] + int'((longint'(TANH_PTS[seg+1] - TANH_PTS[seg]) * frac) >>> 10);
  endfunction

  function automatic int apply_fn(logic [2:0] sel, int x);
    longint a;
    int     t, q;
    a = (x < 0) ? -longint'(x) : longint'(x);
    case (sel)
      lcs_pkg::FN_SIGMOID: begin
        t = tanh_abs(a >> 1) >>> 1;
        return (x < 0) ? 2048 - t : 2048 + t;
      end
      lcs_pkg::FN_HARD: begin
        q = x / 5;
        if (x < 0 && (x % 5) != 0) q--;
        q += 2048;
        if (q < 0) q = 0;
        if (q > 4096) q = 4096;
        return q;
      end
      lcs_pkg::FN_TANH: begin
        t = tanh_abs(a);
        return (x < 0) ? -t : t;
      end
      lcs_pkg::FN_RELU: return (x < 0) ? 0 : x;
      default: return x;
    endcase
  endfunction

  // one time step over the four gates, then cell and hidden update
  task automatic advance_cell(bit emit);
    int     ni, nh, g, k, r, fc, ic, ca;
    longint acc;
    h_beat_t b;
    ni = clamp_len(reg_in_size);
    nh = clamp_len(reg_hid_size);
    for (g = 0; g < 4; g++) begin
      for (k = 0; k < nh; k++) begin
        acc = longint'(bias[g][k]) <<< 12;
        for (r = 0; r < ni; r++) acc += longint'(x_vec[r]) * w_in[g][r][k];
        for (r = 0; r < nh; r++) acc += longint'(h_st[r]) * w_rec[g][r][k];
        gate_v[g][k] = apply_fn((g == lcs_pkg::GATE_CAND) ? reg_cell_fn : reg_gate_fn,
                                sat16(acc >>> 12));
      end
    end
    for (k = 0; k < nh; k++) begin
      fc = sat16((longint'(gate_v[lcs_pkg::GATE_FORGET][k]) * c_st[k]) >>> 12);
      ic = sat16((longint'(gate_v[lcs_pkg::GATE_IN][k]) *
                  gate_v[lcs_pkg::GATE_CAND][k]) >>> 12);
      c_st[k] = sat16(longint'(fc) + ic);
      ca = apply_fn(reg_cell_fn, c_st[k]);
      h_st[k] = sat16((longint'(gate_v[lcs_pkg::GATE_OUT][k]) * ca) >>> 12);
    end
    if (emit) begin
      for (k = 0; k < nh; k++) begin
        b.idx  = k[5:0];
        b.val  = lcs_pkg::data_t'(h_st[k]);
        b.last = (k == nh - 1);
        h_expect_q.push_back(b);
      end
    end
  endtask

  // compare one h beat with the oldest expectation
  task automatic check_h_beat();
    h_beat_t e;
    if (h_expect_q.size() == 0) begin
      $error("h beat with nothing expected: index %0d value %0d",
             out_mon.h_index, out_mon.h_value);
      mismatch_count_o++;
    end else begin
      e = h_expect_q.pop_front();
      if (out_mon.h_index !== e.idx) begin
        $error("h_index expected %0d actual %0d", e.idx, out_mon.h_index);
        mismatch_count_o++;
      end
      if (out_mon.h_value !== e.val) begin
        $error("h_value expected %0d actual %0d", e.val, out_mon.h_value);
        mismatch_count_o++;
      end
      if (out_mon.last_of_run !== e.last) begin
        $error("last_of_run expected %0b actual %0b", e.last, out_mon.last_of_run);
        mismatch_count_o++;
      end
    end
  endtask

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
    reg_in_size      = 7'd64;
    reg_hid_size     = 7'd64;
    reg_gate_fn      = lcs_pkg::FN_HARD;
    reg_cell_fn      = lcs_pkg::FN_TANH;
    reg_ret_seq      = 1'b0;
    foreach (h_st[k]) begin
      h_st[k] = 0;
      c_st[k] = 0;
    end
  end

  // results first: they stem from beats accepted earlier
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_mon.valid && out_mon.ready) check_h_beat();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lcs_pkg::CFG_INPUT_SIZE:  reg_in_size  = cfg_data_i;
          lcs_pkg::CFG_HIDDEN_SIZE: reg_hid_size = cfg_data_i;
          lcs_pkg::CFG_GATE_ACT:    reg_gate_fn  = cfg_data_i[2:0];
          lcs_pkg::CFG_CELL_ACT:    reg_cell_fn  = cfg_data_i[2:0];
          lcs_pkg::CFG_RET_SEQ:     reg_ret_seq  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.action)
          lcs_pkg::ACTION_LOAD_W:
            w_in[in_mon.gate_select][in_mon.row_index][in_mon.col_index] = in_mon.value;
          lcs_pkg::ACTION_LOAD_U:
            w_rec[in_mon.gate_select][in_mon.row_index][in_mon.col_index] = in_mon.value;
          lcs_pkg::ACTION_LOAD_B:
            bias[in_mon.gate_select][in_mon.col_index] = in_mon.value;
          lcs_pkg::ACTION_CLEAR: begin
            foreach (h_st[k]) begin
              h_st[k] = 0;
              c_st[k] = 0;
            end
          end
          lcs_pkg::ACTION_ELEM: begin
            x_vec[in_mon.row_index] = in_mon.value;
            if (in_mon.last_element) advance_cell(reg_ret_seq || in_mon.final_step);
          end
          default: ;
        endcase
      end
      pending_o = h_expect_q.size();
    end
  end

endmodule

/* bench/lstm_cell_sequence_tb.sv */
// top of the lstm cell sequence bench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module lstm_cell_sequence_tb;

  localparam int RUN_LIMIT = 400000;
  localparam int HOLD_CYCLES = 600;
  localparam int FILL_NI = 4;
  localparam int FILL_NH = 4;
  localparam logic [2:0] ACTION_SPARE_LO  = 3'd5;
  localparam logic [2:0] ACTION_SPARE_MID = 3'd6;
  localparam logic [2:0] ACTION_SPARE_HI  = 3'd7;
  localparam logic [2:0] FN_SPARE_LO  = 3'd5;
  localparam logic [2:0] FN_SPARE_MID = 3'd6;
  localparam logic [2:0] FN_SPARE_HI  = 3'd7;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [6:0] cfg_data_i;
  int         mismatch_count;
  int         pending;
  int         cur_ni, cur_nh;
  bit         quiet;
  bit         hold_req;
  int         rx_gap;

  lcs_in_if  in_ch ();
  lcs_out_if out_ch ();

  lstm_cell_sequence DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  lcs_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  initial begin
    repeat (RUN_LIMIT) @(posedge clk_i);
    $display("lstm_cell_sequence_tb failed");
    $finish;
  end

  // result side: random stall bursts, long hold on request
  initial begin
    out_ch.ready = 1'b0;
    rx_gap = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ch.ready = 1'b0;
      end else if (quiet) begin
        out_ch.ready = 1'b1;
      end else if (rx_gap > 0) begin
        out_ch.ready = 1'b0;
        rx_gap--;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ch.ready = 1'b0;
        rx_gap = $urandom_range(0, 4);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // long hold, counted here
  initial begin
    hold_req = 1'b0;
    forever begin
      wait (hold_req);
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_req = 1'b0;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_beat(logic [2:0] act, logic [1:0] gate, logic [5:0] row,
                           logic [5:0] col, lcs_pkg::data_t val, logic last, logic fin);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk_i);
    end
    in_ch.action       = act;
    in_ch.gate_select  = gate;
    in_ch.row_index    = row;
    in_ch.col_index    = col;
    in_ch.value        = val;
    in_ch.last_element = last;
    in_ch.final_step   = fin;
    in_ch.valid        = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  function automatic lcs_pkg::data_t rand_word();
    if ($urandom_range(0, 1)) return lcs_pkg::data_t'($urandom);
    return lcs_pkg::data_t'($signed($urandom_range(0, 8191)) - 4096);
  endfunction

  function automatic int step_cycles(int ni, int nh);
    return 4 * nh * (ni + nh + 6) + 8 * nh;
  endfunction

  function automatic int clamp_len(int n);
    if (n < 1) return 1;
    return (n > 64) ? 64 : n;
  endfunction

  // wait for all h beats, then let any silent step finish
  task automatic settle();
    in_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (5 * step_cycles(cur_ni, cur_nh) + 64) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [6:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  task automatic set_mode(int ni, int nh, logic [2:0] gfn, logic [2:0] cfn, logic rs);
    write_reg(lcs_pkg::CFG_INPUT_SIZE, 7'(ni));
    write_reg(lcs_pkg::CFG_HIDDEN_SIZE, 7'(nh));
    write_reg(lcs_pkg::CFG_GATE_ACT, gfn);
    write_reg(lcs_pkg::CFG_CELL_ACT, cfn);
    write_reg(lcs_pkg::CFG_RET_SEQ, rs);
    cur_ni = clamp_len(ni);
    cur_nh = clamp_len(nh);
  endtask

  // mostly whole input vectors, some loads and noise
  task automatic run_random(int budget);
    int cnt, pick, e;
    cnt = 0;
    while (cnt < budget) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        if ($urandom_range(0, 3) == 0)
          send_beat(lcs_pkg::ACTION_CLEAR, 2'($urandom), 6'($urandom), 6'($urandom),
                    rand_word(), 1'($urandom), 1'($urandom));
        for (e = 0; e < cur_ni; e++)
          send_beat(lcs_pkg::ACTION_ELEM, 2'($urandom), 6'(e), 6'($urandom), rand_word(),
                    e == cur_ni - 1, $urandom_range(0, 2) == 0);
        cnt += cur_ni;
      end else if (pick < 9) begin
        send_beat(3'($urandom_range(lcs_pkg::ACTION_LOAD_W, lcs_pkg::ACTION_LOAD_B)),
                  2'($urandom), 6'($urandom), 6'($urandom), rand_word(), 1'($urandom),
                  1'($urandom));
        cnt++;
      end else begin
        if ($urandom_range(0, 1))
          send_beat(3'($urandom_range(ACTION_SPARE_LO, ACTION_SPARE_HI)), 2'($urandom),
                    6'($urandom), 6'($urandom), lcs_pkg::data_t'($urandom), 1'($urandom),
                    1'($urandom));
        else
          send_beat(lcs_pkg::ACTION_ELEM, 2'($urandom), 6'($urandom), 6'($urandom),
                    lcs_pkg::data_t'($urandom), 1'b0, 1'($urandom));
        cnt++;
      end
    end
    // close the phase with an emitting step
    send_beat(lcs_pkg::ACTION_ELEM, 2'($urandom), 6'(cur_ni - 1), 6'($urandom),
              rand_word(), 1'b1, 1'b1);
  endtask

  // stimulus
  initial begin
    int g, r, c;
    quiet          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = lcs_pkg::CFG_INPUT_SIZE;
    cfg_data_i     = 7'd0;
    in_ch.valid        = 1'b0;
    in_ch.action       = lcs_pkg::ACTION_CLEAR;
    in_ch.gate_select  = lcs_pkg::GATE_IN;
    in_ch.row_index    = 6'd0;
    in_ch.col_index    = 6'd0;
    in_ch.value        = 16'sd0;
    in_ch.last_element = 1'b0;
    in_ch.final_step   = 1'b0;
    cur_ni = 64;
    cur_nh = 64;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // working sizes first, nothing is in flight yet
    set_mode(FILL_NI, FILL_NH, lcs_pkg::FN_HARD, lcs_pkg::FN_TANH, 1'b0);

    // fill every store entry that steps of up to the fill sizes read
    for (g = 0; g < 4; g++) begin
      for (c = 0; c < FILL_NH; c++) begin
        send_beat(lcs_pkg::ACTION_LOAD_B, 2'(g), 6'($urandom), 6'(c),
                  lcs_pkg::data_t'($signed($urandom_range(0, 2047)) - 1024), 1'b0, 1'b0);
        for (r = 0; r < FILL_NI; r++)
          send_beat(lcs_pkg::ACTION_LOAD_W, 2'(g), 6'(r), 6'(c),
                    lcs_pkg::data_t'($signed($urandom_range(0, 8191)) - 4096), 1'b0, 1'b0);
        for (r = 0; r < FILL_NH; r++)
          send_beat(lcs_pkg::ACTION_LOAD_U, 2'(g), 6'(r), 6'(c),
                    lcs_pkg::data_t'($signed($urandom_range(0, 8191)) - 4096), 1'b0, 1'b0);
      end
    end
    for (r = 0; r < FILL_NI; r++)
      send_beat(lcs_pkg::ACTION_ELEM, lcs_pkg::GATE_IN, 6'(r), 6'd0, rand_word(), 1'b0, 1'b0);

    // directed: extremes, spare actions, silent then emitting steps
    send_beat(lcs_pkg::ACTION_LOAD_W, lcs_pkg::GATE_OUT, 6'd63, 6'd63, -16'sd32768,
              1'b1, 1'b1);
    send_beat(lcs_pkg::ACTION_LOAD_U, lcs_pkg::GATE_IN, 6'd0, 6'd0, 16'sd32767, 1'b1, 1'b0);
    send_beat(lcs_pkg::ACTION_LOAD_B, lcs_pkg::GATE_CAND, 6'd63, 6'd63, 16'sd32767,
              1'b0, 1'b1);
    send_beat(lcs_pkg::ACTION_LOAD_B, lcs_pkg::GATE_FORGET, 6'd0, 6'd0, -16'sd32768,
              1'b0, 1'b0);
    send_beat(ACTION_SPARE_LO, lcs_pkg::GATE_OUT, 6'd63, 6'd63, 16'sd32767, 1'b1, 1'b1);
    send_beat(ACTION_SPARE_MID, lcs_pkg::GATE_IN, 6'd0, 6'd0, -16'sd1, 1'b1, 1'b1);
    send_beat(ACTION_SPARE_HI, lcs_pkg::GATE_CAND, 6'd5, 6'd9, 16'sd0, 1'b0, 1'b0);
    send_beat(lcs_pkg::ACTION_ELEM, lcs_pkg::GATE_IN, 6'd63, 6'd0, 16'sd32767, 1'b0, 1'b1);
    send_beat(lcs_pkg::ACTION_ELEM, lcs_pkg::GATE_IN, 6'd0, 6'd0, -16'sd32768, 1'b1, 1'b0);
    send_beat(lcs_pkg::ACTION_ELEM, lcs_pkg::GATE_OUT, 6'd1, 6'd63, 16'sd4096, 1'b1, 1'b1);
    send_beat(lcs_pkg::ACTION_CLEAR, lcs_pkg::GATE_OUT, 6'd63, 6'd63, 16'sd32767,
              1'b1, 1'b1);
    send_beat(lcs_pkg::ACTION_ELEM, lcs_pkg::GATE_IN, 6'd2, 6'd0, -16'sd4096, 1'b1, 1'b1);
    settle();

    // phases over sizes and activations, a clamped size and spare codes too
    set_mode(3, 4, lcs_pkg::FN_SIGMOID, lcs_pkg::FN_TANH, 1'b1);
    run_random(20);
    settle();
    set_mode(1, 1, lcs_pkg::FN_HARD, lcs_pkg::FN_SIGMOID, 1'b0);
    run_random(12);
    settle();
    set_mode(0, 2, lcs_pkg::FN_TANH, lcs_pkg::FN_LINEAR, 1'b1);
    run_random(12);
    settle();

    // result side holds off while input keeps coming and the queue fills
    set_mode(4, 3, lcs_pkg::FN_RELU, lcs_pkg::FN_RELU, 1'b1);
    hold_req = 1'b1;
    run_random(28);
    settle();

    set_mode(2, 3, lcs_pkg::FN_LINEAR, lcs_pkg::FN_HARD, 1'b0);
    run_random(16);
    settle();
    set_mode(4, 4, FN_SPARE_LO, FN_SPARE_MID, 1'b1);
    run_random(16);
    settle();
    set_mode(2, 2, FN_SPARE_HI, lcs_pkg::FN_SIGMOID, 1'b1);
    run_random(16);
    settle();

    // last part without any idling, largest filled sizes
    quiet = 1'b1;
    set_mode(FILL_NI, FILL_NH, lcs_pkg::FN_HARD, lcs_pkg::FN_TANH, 1'b0);
    run_random(20);
    settle();

    if (mismatch_count == 0) begin
      $display("lstm_cell_sequence_tb passed");
    end else begin
      $display("lstm_cell_sequence_tb failed");
    end
    $finish;
  end

endmodule
